// ----- sv/h2r_pkg.sv -----
// Package for the HSV to RGB converter: hue constants, sector codes and the
// per-sector channel weight table. No dependencies.

package h2r_pkg;

  // Hue is a signed count of 1/64 degree.
  localparam int unsigned HUE_W = 16;
  // One 60-degree sector in hue counts.
  localparam int unsigned HUE_SECTOR = 3840;
  // Offset that maps a negative hue onto 0..46079 (2^16 minus two full turns).
  localparam int unsigned HUE_NEG_OFS = 19456;
  // Sectors in two full turns, and sectors in one turn.
  localparam int unsigned HUE_SEGMENTS = 12;
  localparam int unsigned SECTORS = 6;

  // Width of a chroma weight (0..3840).
  localparam int unsigned WEIGHT_W = 12;

  // Sector codes, named after the hue span each one covers.
  localparam logic [2:0] SECT_RY = 3'd0;  // red to yellow
  localparam logic [2:0] SECT_YG = 3'd1;  // yellow to green
  localparam logic [2:0] SECT_GC = 3'd2;  // green to cyan
  localparam logic [2:0] SECT_CB = 3'd3;  // cyan to blue
  localparam logic [2:0] SECT_BM = 3'd4;  // blue to magenta
  localparam logic [2:0] SECT_MR = 3'd5;  // magenta to red

  // Missing chroma per channel, in 1/3840 of chroma: a channel sits at
  // v - c * u / 3840, so u = 0 puts it at v and u = 3840 puts it at m.
  typedef struct packed {
    logic [WEIGHT_W-1:0] r;
    logic [WEIGHT_W-1:0] g;
    logic [WEIGHT_W-1:0] b;
  } weights_t;

  // Channel order per sector; k is the secondary weight inside the sector.
  function automatic weights_t h2r_weights(logic [2:0] sector, logic [WEIGHT_W-1:0] k);
    weights_t u;
    logic [WEIGHT_W-1:0] rest;
    logic [WEIGHT_W-1:0] full;
    full = WEIGHT_W'(HUE_SECTOR);
    rest = full - k;
    unique case (sector)
      SECT_RY: begin
        u.r = '0;   u.g = rest; u.b = full;
      end
      SECT_YG: begin
        u.r = rest; u.g = '0;   u.b = full;
      end
      SECT_GC: begin
        u.r = full; u.g = '0;   u.b = rest;
      end
      SECT_CB: begin
        u.r = full; u.g = rest; u.b = '0;
      end
      SECT_BM: begin
        u.r = rest; u.g = full; u.b = '0;
      end
      default: begin
        u.r = '0;   u.g = full; u.b = rest;
      end
    endcase
    return u;
  endfunction

endpackage

// ----- sv/h2r_front.sv -----
// Front stage of the HSV to RGB converter: accepts an item, wraps the hue,
// finds its sector and weights and clamps s and v. Depends on h2r_pkg.

module h2r_front #(
  parameter int unsigned CHANNEL_FRAC_BITS = 8
) (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  logic                                  in_valid_i,
  output logic                                  in_ready_o,
  input  logic [h2r_pkg::HUE_W-1:0]             hue_i,
  input  logic [CHANNEL_FRAC_BITS:0]            sat_i,
  input  logic [CHANNEL_FRAC_BITS:0]            bright_i,
  output logic                                  out_valid_o,
  input  logic                                  out_ready_i,
  output logic [$bits(h2r_pkg::weights_t)+2*(CHANNEL_FRAC_BITS+1)-1:0] out_data_o
);

  localparam int unsigned CW = CHANNEL_FRAC_BITS + 1;
  localparam int unsigned TW = h2r_pkg::HUE_W + 1;
  localparam int unsigned QW = $bits(h2r_pkg::weights_t) + 2 * CW;
  localparam logic [CW-1:0] ONE = {1'b1, {CHANNEL_FRAC_BITS{1'b0}}};

  logic [TW-1:0] hue_t;
  logic [3:0] seg;
  logic [TW-1:0] frac_full;
  logic [h2r_pkg::WEIGHT_W-1:0] frac;
  logic [h2r_pkg::WEIGHT_W-1:0] k;
  logic [2:0] sector;
  h2r_pkg::weights_t weights;
  logic [CW-1:0] sat_c;
  logic [CW-1:0] bright_c;
  logic accept;

  logic valid_q, valid_d;
  logic [QW-1:0] data_q;

  // Bring a negative hue up so that every hue lands in 0..46079.
  always_comb begin
    if (hue_i[h2r_pkg::HUE_W-1]) begin
      hue_t = {1'b0, hue_i} - TW'(h2r_pkg::HUE_NEG_OFS);
    end else begin
      hue_t = {1'b0, hue_i};
    end
  end

  // Segment over two turns from independent threshold compares.
  always_comb begin
    seg = '0;
    for (int i = 1; i < h2r_pkg::HUE_SEGMENTS; i++) begin
      if (hue_t >= TW'(i * h2r_pkg::HUE_SECTOR)) begin
        seg = 4'(i);
      end
    end
  end

  // Offset inside the sector, mirrored in odd sectors.
  always_comb begin
    frac_full = hue_t - TW'(seg) * TW'(h2r_pkg::HUE_SECTOR);
    frac      = frac_full[h2r_pkg::WEIGHT_W-1:0];
    if (seg >= 4'(h2r_pkg::SECTORS)) begin
      sector = 3'(seg - 4'(h2r_pkg::SECTORS));
    end else begin
      sector = seg[2:0];
    end
    if (sector[0]) begin
      k = h2r_pkg::WEIGHT_W'(h2r_pkg::HUE_SECTOR) - frac;
    end else begin
      k = frac;
    end
    weights = h2r_pkg::h2r_weights(sector, k);
  end

  // Saturation and value above one are held at one.
  assign sat_c    = (sat_i > ONE) ? ONE : sat_i;
  assign bright_c = (bright_i > ONE) ? ONE : bright_i;

  // Output register: takes a new item while the previous one moves on.
  assign in_ready_o = !valid_q || out_ready_i;
  assign accept     = in_valid_i && in_ready_o;

  always_comb begin
    valid_d = valid_q;
    if (accept) begin
      valid_d = 1'b1;
    end else if (out_ready_i) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      data_q <= {weights, bright_c, sat_c};
    end
  end

  assign out_valid_o = valid_q;
  assign out_data_o  = data_q;

endmodule

// ----- sv/h2r_fifo.sv -----
// Small register queue between the front and back of the HSV to RGB
// converter. No dependencies.

module h2r_fifo #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 4
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  logic [WIDTH-1:0] push_data_i,
  output logic             full_o,
  input  logic             pop_i,
  output logic [WIDTH-1:0] pop_data_o,
  output logic             empty_o
);

  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [AW-1:0] wr_ptr_q, wr_ptr_d;
  logic [AW-1:0] rd_ptr_q, rd_ptr_d;
  logic [AW:0] count_q, count_d;
  logic do_push;
  logic do_pop;

  assign full_o     = (count_q == (AW + 1)'(DEPTH));
  assign empty_o    = (count_q == '0);
  assign do_push    = push_i && !full_o;
  assign do_pop     = pop_i && !empty_o;
  assign pop_data_o = mem_q[rd_ptr_q];

  // Pointer and fill count update.
  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == AW'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == AW'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (do_push && !do_pop) begin
      count_d = count_q + 1'b1;
    end else if (do_pop && !do_push) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  // Storage needs no reset.
  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= push_data_i;
    end
  end

endmodule

// ----- sv/h2r_back.sv -----
// Back pipeline of the HSV to RGB converter: chroma, weighted chroma, exact
// division by 3840 * 2^F and the output register. Depends on h2r_pkg.

module h2r_back #(
  parameter int unsigned CHANNEL_FRAC_BITS = 8
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [$bits(h2r_pkg::weights_t)+2*(CHANNEL_FRAC_BITS+1)-1:0] in_data_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [CHANNEL_FRAC_BITS:0] red_o,
  output logic [CHANNEL_FRAC_BITS:0] green_o,
  output logic [CHANNEL_FRAC_BITS:0] blue_o
);

  localparam int unsigned F   = CHANNEL_FRAC_BITS;
  localparam int unsigned CW  = F + 1;
  localparam int unsigned UW  = h2r_pkg::WEIGHT_W;
  // Chroma v*s is at most 2^2F.
  localparam int unsigned C2W = 2 * F + 1;
  // Weighted chroma c2*u.
  localparam int unsigned PW  = C2W + UW;
  // 3840 * 2^F = 15 * 2^(F+8): shift by F+8 rounding up, then divide by 15.
  localparam int unsigned SH  = F + 8;
  localparam int unsigned NW  = F + 4;
  localparam int unsigned MW  = F + 5;
  localparam int unsigned MULW = NW + MW;
  localparam int unsigned RECIP = ((2 ** SH) + 14) / 15;
  localparam logic [PW-1:0] RND = PW'((2 ** SH) - 1);
  localparam logic [NW-1:0] DIV_BIAS = NW'(14);

  h2r_pkg::weights_t in_w;
  logic [CW-1:0] in_v;
  logic [CW-1:0] in_s;
  logic en;

  // Stage valid flags.
  logic vld1_q, vld2_q, vld3_q, vld4_q, out_vld_q;

  // Stage payloads.
  logic [C2W-1:0] c2_q;
  h2r_pkg::weights_t u1_q;
  logic [CW-1:0] v1_q, v2_q, v3_q, v4_q;
  logic [PW-1:0] p_q [3];
  logic [NW-1:0] n_q [3];
  logic [MULW-1:0] prod_q [3];
  logic [CW-1:0] chan_q [3];

  logic [PW-1:0] p_d [3];
  logic [NW-1:0] n_d [3];
  logic [MULW-1:0] prod_d [3];
  logic [CW-1:0] chan_d [3];

  assign {in_w, in_v, in_s} = in_data_i;

  // The whole pipeline advances unless a result waits at the output.
  assign en         = !out_vld_q || out_ready_i;
  assign in_ready_o = en;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld1_q    <= 1'b0;
      vld2_q    <= 1'b0;
      vld3_q    <= 1'b0;
      vld4_q    <= 1'b0;
      out_vld_q <= 1'b0;
    end else if (en) begin
      vld1_q    <= in_valid_i;
      vld2_q    <= vld1_q;
      vld3_q    <= vld2_q;
      vld4_q    <= vld3_q;
      out_vld_q <= vld4_q;
    end
  end

  // Per-channel arithmetic of stages two to five.
  always_comb begin
    p_d[0] = PW'(c2_q) * PW'(u1_q.r);
    p_d[1] = PW'(c2_q) * PW'(u1_q.g);
    p_d[2] = PW'(c2_q) * PW'(u1_q.b);
    for (int i = 0; i < 3; i++) begin
      logic [PW-1:0] ps;
      ps = p_q[i] + RND;
      // ceil(p / 2^(F+8)) + 14, ready for a floor division by 15
      n_d[i]    = ps[SH+NW-1:SH] + DIV_BIAS;
      prod_d[i] = MULW'(n_q[i]) * MULW'(RECIP);
      chan_d[i] = v4_q - prod_q[i][SH+CW-1:SH];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      c2_q <= C2W'(in_v) * C2W'(in_s);
      u1_q <= in_w;
      v1_q <= in_v;
      v2_q <= v1_q;
      v3_q <= v2_q;
      v4_q <= v3_q;
      for (int i = 0; i < 3; i++) begin
        p_q[i]    <= p_d[i];
        n_q[i]    <= n_d[i];
        prod_q[i] <= prod_d[i];
        chan_q[i] <= chan_d[i];
      end
    end
  end

  assign out_valid_o = out_vld_q;
  assign red_o       = chan_q[0];
  assign green_o     = chan_q[1];
  assign blue_o      = chan_q[2];

endmodule

// ----- sv/hsv_to_rgb_converter_core.sv -----
// HSV to RGB converter, top level: front stage, queue and back pipeline.
// Depends on h2r_pkg, h2r_front, h2r_fifo and h2r_back.
//
// Usage:
//   One HSV item in on the s_axis channel, one RGB item out on m_axis.
//   Hue is a signed count of 1/64 degree and is wrapped into one turn;
//   saturation, value and the channels are Q1.F with F = CHANNEL_FRAC_BITS,
//   inputs above one are treated as one, channels are truncated.
//   An accepted item passes the front register, the queue and the five back
//   stages before it reaches m_axis_tvalid. Throughput is one item per cycle
//   while the receiver is ready: the front stage, the four-entry queue and
//   the five-stage back pipeline all take a new item every clock.
//   When the receiver stalls, the back pipeline holds and the queue fills;
//   s_axis_tready drops only once the queue and the front register are full.
//   Reset clears all valid flags and the queue pointers; the block is ready
//   right after reset and needs no clearing pass.

module hsv_to_rgb_converter_core #(
  parameter int unsigned CHANNEL_FRAC_BITS = 8
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic s_axis_tvalid,
  output logic s_axis_tready,
  // hue_angle [15:0], saturation, brightness; zero pad to whole bytes
  input  logic [((2*CHANNEL_FRAC_BITS+18+7)/8)*8-1:0] s_axis_tdata,
  output logic m_axis_tvalid,
  input  logic m_axis_tready,
  // red, green, blue (F+1 bits each); zero pad to whole bytes
  output logic [((3*CHANNEL_FRAC_BITS+3+7)/8)*8-1:0] m_axis_tdata
);

  localparam int unsigned F      = CHANNEL_FRAC_BITS;
  localparam int unsigned CW     = F + 1;
  localparam int unsigned HW     = h2r_pkg::HUE_W;
  localparam int unsigned QW     = $bits(h2r_pkg::weights_t) + 2 * CW;
  localparam int unsigned OUT_W  = ((3 * F + 3 + 7) / 8) * 8;
  localparam int unsigned QDEPTH = 4;

  logic fr_valid;
  logic fr_ready;
  logic [QW-1:0] fr_data;
  logic q_full;
  logic q_empty;
  logic [QW-1:0] q_data;
  logic bk_ready;
  logic [CW-1:0] red;
  logic [CW-1:0] green;
  logic [CW-1:0] blue;

  h2r_front #(
    .CHANNEL_FRAC_BITS(CHANNEL_FRAC_BITS)
  ) u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .in_ready_o (s_axis_tready),
    .hue_i      (s_axis_tdata[HW-1:0]),
    .sat_i      (s_axis_tdata[HW+CW-1:HW]),
    .bright_i   (s_axis_tdata[HW+2*CW-1:HW+CW]),
    .out_valid_o(fr_valid),
    .out_ready_i(fr_ready),
    .out_data_o (fr_data)
  );

  assign fr_ready = !q_full;

  h2r_fifo #(
    .WIDTH(QW),
    .DEPTH(QDEPTH)
  ) u_queue (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (fr_valid),
    .push_data_i(fr_data),
    .full_o     (q_full),
    .pop_i      (bk_ready),
    .pop_data_o (q_data),
    .empty_o    (q_empty)
  );

  h2r_back #(
    .CHANNEL_FRAC_BITS(CHANNEL_FRAC_BITS)
  ) u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (!q_empty),
    .in_ready_o (bk_ready),
    .in_data_i  (q_data),
    .out_valid_o(m_axis_tvalid),
    .out_ready_i(m_axis_tready),
    .red_o      (red),
    .green_o    (green),
    .blue_o     (blue)
  );

  assign m_axis_tdata = OUT_W'({blue, green, red});

endmodule

// ----- sv/h2r_checker.sv -----
// Port-level checks for the HSV to RGB converter, bound to the top level.
// Depends on hsv_to_rgb_converter_core.

module h2r_checker #(
  parameter int unsigned CHANNEL_FRAC_BITS = 8
) (
  input logic clk_i,
  input logic rst_ni,
  input logic m_axis_tvalid,
  input logic m_axis_tready,
  input logic [((3*CHANNEL_FRAC_BITS+3+7)/8)*8-1:0] m_axis_tdata
);

  localparam int unsigned CW = CHANNEL_FRAC_BITS + 1;
  localparam logic [CW-1:0] ONE = {1'b1, {CHANNEL_FRAC_BITS{1'b0}}};

  // No item comes out while reset is held.
  a_no_valid_in_reset: assert property (@(posedge clk_i) !rst_ni |-> !m_axis_tvalid)
    else $error("output valid during reset");

  // Each channel stays within 0..1.0.
  a_channel_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> (m_axis_tdata[CW-1:0] <= ONE) &&
                      (m_axis_tdata[2*CW-1:CW] <= ONE) &&
                      (m_axis_tdata[3*CW-1:2*CW] <= ONE))
    else $error("channel above one");

  // Pad bits above the three channels are zero.
  a_pad_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> ((m_axis_tdata >> (3 * CW)) == '0))
    else $error("nonzero pad bits in output item");

  // A stalled item stays valid and unchanged.
  a_hold_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
    else $error("output item dropped while stalled");

  a_hold_data: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> $stable(m_axis_tdata))
    else $error("output item changed while stalled");

endmodule

bind hsv_to_rgb_converter_core h2r_checker #(
  .CHANNEL_FRAC_BITS(CHANNEL_FRAC_BITS)
) u_h2r_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .m_axis_tvalid(m_axis_tvalid),
  .m_axis_tready(m_axis_tready),
  .m_axis_tdata (m_axis_tdata)
);

// ----- dv/tb_hsv_to_rgb_converter_core.sv -----
`timescale 1ns / 1ps
// Self-checking testbench for hsv_to_rgb_converter_core: drives HSV items on
// the slave stream and checks each RGB item against a local color predictor.
// Depends on h2r_pkg and the converter RTL.

module tb_hsv_to_rgb_converter_core;

  localparam int unsigned CF    = 8;
  localparam int unsigned CW    = CF + 1;
  localparam int unsigned IN_W  = ((2 * CF + 18 + 7) / 8) * 8;
  localparam int unsigned OUT_W = ((3 * CF + 3 + 7) / 8) * 8;
  localparam int unsigned ONE   = 1 << CF;
  localparam int          TURN  = h2r_pkg::SECTORS * h2r_pkg::HUE_SECTOR;
  localparam int          LONG_HOLD = 60;

  // Red sits in the lowest bits of the output item.
  typedef struct packed {
    logic [CW-1:0] blue;
    logic [CW-1:0] green;
    logic [CW-1:0] red;
  } rgb_t;

  // Holds the RGB colors still owed by the block, oldest first, and counts
  // what has been compared.
  class color_ledger;
    rgb_t        rgb_due[$];
    int unsigned errors;
    int unsigned checked;
    int unsigned sector_hits[h2r_pkg::SECTORS];

    // Wraps the hue into one turn, clamps s and v to one and mixes the
    // chroma weights of the sector on top of m = v - c.
    function rgb_t convert_color(logic signed [15:0] hue, logic [CW-1:0] sat,
                                 logic [CW-1:0] bri);
      int              h;
      int unsigned     sect;
      int unsigned     ofs;
      int unsigned     k;
      longint unsigned s;
      longint unsigned v;
      longint unsigned c2;
      longint unsigned wt[3];
      longint unsigned lvl[3];
      rgb_t            rgb;
      h = int'(hue) % TURN;
      if (h < 0) h += TURN;
      s = (sat > ONE) ? ONE : sat;
      v = (bri > ONE) ? ONE : bri;
      sect = h / h2r_pkg::HUE_SECTOR;
      ofs  = h % h2r_pkg::HUE_SECTOR;
      k    = sect[0] ? h2r_pkg::HUE_SECTOR - ofs : ofs;
      sector_hits[sect]++;
      c2 = v * s;
      unique case (3'(sect))
        h2r_pkg::SECT_RY: wt = '{h2r_pkg::HUE_SECTOR, k, 0};
        h2r_pkg::SECT_YG: wt = '{k, h2r_pkg::HUE_SECTOR, 0};
        h2r_pkg::SECT_GC: wt = '{0, h2r_pkg::HUE_SECTOR, k};
        h2r_pkg::SECT_CB: wt = '{0, k, h2r_pkg::HUE_SECTOR};
        h2r_pkg::SECT_BM: wt = '{k, 0, h2r_pkg::HUE_SECTOR};
        default:          wt = '{h2r_pkg::HUE_SECTOR, 0, k};
      endcase
      for (int i = 0; i < 3; i++) begin
        lvl[i] = ((v * ONE - c2) * h2r_pkg::HUE_SECTOR + c2 * wt[i])
                 / (h2r_pkg::HUE_SECTOR * ONE);
      end
      rgb.red   = lvl[0][CW-1:0];
      rgb.green = lvl[1][CW-1:0];
      rgb.blue  = lvl[2][CW-1:0];
      return rgb;
    endfunction

    function void note_hsv(logic [15:0] hue, logic [CW-1:0] sat, logic [CW-1:0] bri);
      rgb_due.push_back(convert_color(hue, sat, bri));
    endfunction

    function void check_rgb(logic [OUT_W-1:0] data);
      rgb_t got;
      rgb_t want;
      got = data[3*CW-1:0];
      if (rgb_due.size() == 0) begin
        $display("%0t: RGB item with nothing outstanding: expected none, actual %h",
                 $time, got);
        errors++;
        return;
      end
      want = rgb_due.pop_front();
      checked++;
      if (got.red !== want.red) begin
        $display("%0t: red mismatch: expected %0d, actual %0d", $time, want.red, got.red);
        errors++;
      end
      if (got.green !== want.green) begin
        $display("%0t: green mismatch: expected %0d, actual %0d", $time, want.green,
                 got.green);
        errors++;
      end
      if (got.blue !== want.blue) begin
        $display("%0t: blue mismatch: expected %0d, actual %0d", $time, want.blue,
                 got.blue);
        errors++;
      end
    endfunction

    function int pending();
      return rgb_due.size();
    endfunction
  endclass

  logic             clk_i;
  logic             rst_ni        = 1'b1;
  logic             s_axis_tvalid = 1'b0;
  logic             s_axis_tready;
  logic [IN_W-1:0]  s_axis_tdata  = '0;
  logic             m_axis_tvalid;
  logic             m_axis_tready = 1'b0;
  logic [OUT_W-1:0] m_axis_tdata;

  color_ledger ledger = new;

  // Idling controls, all set by the sender; rx_calm and hold_req steer the receiver.
  bit tx_calm   = 1'b0;
  bit rx_calm   = 1'b0;
  bit hold_req  = 1'b0;

  hsv_to_rgb_converter_core #(
    .CHANNEL_FRAC_BITS(CF)
  ) uut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata)
  );

  // 100 MHz clock.
  always begin
    clk_i = 1'b0;
    #5;
    clk_i = 1'b1;
    #5;
  end

  // Offers one HSV item after a gap and waits until the block takes it.
  task automatic offer_hsv(input logic [15:0] hue, input logic [CW-1:0] sat,
                           input logic [CW-1:0] bri, input int gap);
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {{(IN_W - 2 * CW - 16){1'b0}}, bri, sat, hue};
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    ledger.note_hsv(hue, sat, bri);
  endtask

  // Mostly legal levels, with the ends and the above-one range mixed in.
  function automatic logic [CW-1:0] draw_level();
    int unsigned r;
    r = $urandom_range(0, 9);
    if (r < 7) return CW'($urandom_range(0, ONE));
    if (r == 7) return CW'(ONE);
    if (r == 8) return '0;
    return CW'($urandom_range(ONE + 1, (1 << CW) - 1));
  endfunction

  // Sender: directed corners first, then random phases with a long receiver
  // hold and a full drain in between.
  initial begin : stimulus
    shortint       dir_hue[24] = '{0, 3840, 7680, 11520, 15360, 19200, 23040, -1,
                                   -32768, 32767, -23040, -3840, 1920, 5760, 0, 0,
                                   9000, 12000, 17000, 21000, 3839, 3841,
                                   16'h5555, 16'hAAAA};
    int unsigned   dir_sat[24] = '{256, 256, 256, 256, 256, 256, 256, 256, 256, 256,
                                   200, 128, 256, 128, 0, 0, 256, 511, 256, 511,
                                   256, 256, 9'h155, 9'h0AA};
    int unsigned   dir_bri[24] = '{256, 256, 256, 256, 256, 256, 256, 256, 256, 256,
                                   180, 256, 256, 200, 0, 256, 0, 256, 511, 511,
                                   256, 256, 9'h0AA, 9'h155};
    logic [15:0]   hue;
    int            burst_left;
    int            gap;
    int            drain;

    // Reset goes active at time zero so the block's valid flags and queue pointers start defined.
    rst_ni <= 1'b0;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    for (int i = 0; i < 24; i++) begin
      offer_hsv(dir_hue[i], CW'(dir_sat[i]), CW'(dir_bri[i]), $urandom_range(0, 6));
    end

    burst_left = 0;
    for (int i = 0; i < 900; i++) begin
      // Phases alternate between both sides idling, a busy sender and a
      // busy receiver.
      tx_calm = ((i / 100) % 3 == 1);
      rx_calm = ((i / 100) % 3 == 2);
      if (i == 300) begin
        // Long receiver hold while items keep coming, so the queue fills up.
        hold_req   = 1'b1;
        burst_left = 30;
      end
      if (i == 600) begin
        // Let the block run dry before going on.
        s_axis_tvalid <= 1'b0;
        while (ledger.pending() != 0) @(posedge clk_i);
      end
      if ($urandom_range(0, 4) == 0) begin
        hue = 16'(int'($urandom_range(0, 12)) * TURN / h2r_pkg::SECTORS - TURN
                  + int'($urandom_range(0, 4)) - 2);
      end else begin
        hue = 16'($urandom);
      end
      gap = (tx_calm || burst_left > 0) ? 0 : $urandom_range(0, 6);
      if (burst_left > 0) burst_left--;
      offer_hsv(hue, draw_level(), draw_level(), gap);
    end
    s_axis_tvalid <= 1'b0;

    drain = 0;
    while (ledger.pending() != 0 && drain < 5000) begin
      @(posedge clk_i);
      drain++;
    end
    repeat (20) @(posedge clk_i);
    if (ledger.pending() != 0) begin
      $display("%0t: %0d RGB items never arrived: expected 0 outstanding, actual %0d",
               $time, ledger.pending(), ledger.pending());
      ledger.errors++;
    end

    $display("Checked %0d RGB items from 924 HSV items, %0d mismatches.",
             ledger.checked, ledger.errors);
    $display("Hue sectors hit: %0d %0d %0d %0d %0d %0d", ledger.sector_hits[0],
             ledger.sector_hits[1], ledger.sector_hits[2], ledger.sector_hits[3],
             ledger.sector_hits[4], ledger.sector_hits[5]);
    if (ledger.errors == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

  // Receiver: checks each accepted RGB item and draws a stall before the
  // next one; a hold request drops tready for a long stretch.
  initial begin : receiver
    int stall_left;
    stall_left = 0;
    @(posedge rst_ni);
    forever begin
      @(posedge clk_i);
      if (m_axis_tvalid && m_axis_tready) begin
        ledger.check_rgb(m_axis_tdata);
        stall_left = rx_calm ? 0 : $urandom_range(0, 6);
      end
      if (hold_req) begin
        hold_req   = 1'b0;
        stall_left = LONG_HOLD;
      end
      if (stall_left > 0) begin
        m_axis_tready <= 1'b0;
        stall_left--;
      end else begin
        m_axis_tready <= 1'b1;
      end
    end
  end

  // Hang guard, far beyond the slowest legal run.
  initial begin : watchdog
    #2_000_000;
    $display("[FAIL] regression broken");
    $finish;
  end

endmodule
